// ----- hw/rtl/spf_pkg.sv -----
// shared constants and controller/datapath interface structs for the polygon fill core
// no dependencies

package spf_pkg;

   localparam int COORD_W              = 9;
   localparam int LEFT_W               = 10;
   localparam int DEF_SCREEN_ROWS      = 512;
   localparam int DEF_SLOPE_FRAC_BITS  = 16;
   localparam logic [LEFT_W-1:0] LEFT_UNTOUCHED = 10'd512;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam logic EDGE_PREV_TO_CUR  = 1'b0;
   localparam logic EDGE_CUR_TO_START = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // capture the incoming item
      logic clr_step;    // write one row of the clearing pass
      logic load_edge;   // latch and sort endpoints of the next edge
      logic edge_sel;
      logic div_step;    // one quotient bit of the slope
      logic walk_step;   // issue one row of the edge walk
      logic q_read;      // read the tables at the query row
      logic rsp_load;    // move the query answer to the output register
   } spf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic walk_last;
      logic rsp_free;
   } spf_sts_type;

endpackage

// ----- hw/rtl/spf_ctrl.sv -----
// sequencing state machine for the polygon fill core
// depends on spf_pkg

module spf_ctrl import spf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        item_kind,
   input  logic        item_first,
   input  logic        item_last,
   input  spf_sts_type sts,
   output spf_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_EDGE, ST_DIV, ST_WALK, ST_DRAIN, ST_QREAD, ST_QOUT
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      sel_ff, sel_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.edge_sel = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               if (item_kind == KIND_QUERY) begin
                  state_in = ST_QREAD;
               end else if (item_first) begin
                  pend_in  = item_last;
                  state_in = ST_CLEAR;
               end else begin
                  pend_in  = item_last;
                  sel_in   = EDGE_PREV_TO_CUR;
                  state_in = ST_EDGE;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  sel_in   = EDGE_CUR_TO_START;
                  state_in = ST_EDGE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EDGE: begin
            cmd.load_edge = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pend_ff) begin
               pend_in  = 1'b0;
               sel_in   = EDGE_CUR_TO_START;
               state_in = ST_EDGE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QREAD: begin
            cmd.q_read = 1'b1;
            state_in   = ST_QOUT;
         end
         ST_QOUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
         sel_ff   <= EDGE_PREV_TO_CUR;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         sel_ff   <= sel_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");
   a_walk_ends_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && sts.walk_last) |=> (state_ff == ST_DRAIN))
      else $error("edge walk did not drain its last write");
   a_query_answered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QOUT && sts.rsp_free) |-> cmd.rsp_load)
      else $error("query answer not loaded while output free");
`endif

endmodule

// ----- hw/rtl/spf_dpath.sv -----
// datapath: vertex registers, slope divider, edge walker and row edge tables
// depends on spf_pkg

module spf_dpath import spf_pkg::*; #(
   parameter int SCREEN_ROWS     = DEF_SCREEN_ROWS,
   parameter int SLOPE_FRAC_BITS = DEF_SLOPE_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  spf_cmd_type        cmd,
   output spf_sts_type        sts,
   input  logic [COORD_W-1:0] item_x,
   input  logic [COORD_W-1:0] item_y,
   input  logic               item_first,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic               span_valid,
   output logic [LEFT_W-1:0]  span_left,
   output logic [COORD_W-1:0] span_right
);

   localparam int AW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int XW = COORD_W + SLOPE_FRAC_BITS;   // x and slope magnitude
   localparam int CW = $clog2(XW);
   localparam int RW = 14;                          // wide enough to compare rows

   logic [LEFT_W-1:0]  left_mem  [SCREEN_ROWS];
   logic [COORD_W-1:0] right_mem [SCREEN_ROWS];

   logic [COORD_W-1:0] cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff, start_x_ff, start_y_ff;
   logic [AW-1:0]      clr_ff;
   logic [XW-1:0]      num_ff, x_ff;
   logic [COORD_W-1:0] rem_ff, dy_ff, row_ff, top_ff;
   logic [CW-1:0]      cnt_ff;
   logic               neg_ff;
   logic               s2_valid_ff;
   logic [AW-1:0]      s2_row_ff;
   logic [COORD_W-1:0] s2_xi_ff;
   logic [LEFT_W-1:0]  left_rd_ff;
   logic [COORD_W-1:0] right_rd_ff;
   logic               q_ok_ff;
   logic               rsp_valid_ff;
   logic               span_valid_ff;
   logic [LEFT_W-1:0]  span_left_ff;
   logic [COORD_W-1:0] span_right_ff;

   // edge endpoint selection and sorting
   logic [COORD_W-1:0] ax, ay, bx, by, lo_x, lo_y, hi_x, hi_y;
   logic [COORD_W:0]   dx;
   logic [COORD_W-1:0] dx_mag;
   logic [COORD_W:0]   rem_sh;
   logic               q_bit;
   logic [AW-1:0]      rd_addr;
   logic               rd_en;
   logic               row_ok;
   logic               left_we, right_we;
   logic [AW-1:0]      wr_addr;
   logic [LEFT_W-1:0]  left_wd;
   logic [COORD_W-1:0] right_wd;
   logic [LEFT_W-1:0]  q_left;
   logic [COORD_W-1:0] q_right;

   always_comb begin
      if (cmd.edge_sel == EDGE_CUR_TO_START) begin
         ax = cur_x_ff;   ay = cur_y_ff;   bx = start_x_ff; by = start_y_ff;
      end else begin
         ax = prev_x_ff;  ay = prev_y_ff;  bx = cur_x_ff;   by = cur_y_ff;
      end
      if (by < ay) begin
         lo_x = bx; lo_y = by; hi_x = ax; hi_y = ay;
      end else begin
         lo_x = ax; lo_y = ay; hi_x = bx; hi_y = by;
      end
      dx     = {1'b0, hi_x} - {1'b0, lo_x};
      dx_mag = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
   end

   // restoring division, one quotient bit per cycle
   assign rem_sh = {rem_ff, num_ff[XW-1]};
   assign q_bit  = (rem_sh >= {1'b0, dy_ff});

   assign row_ok  = (RW'(row_ff) < RW'(SCREEN_ROWS));
   assign rd_en   = cmd.walk_step || cmd.q_read;
   assign rd_addr = cmd.q_read ? AW'(cur_y_ff) : AW'(row_ff);

   always_comb begin
      if (cmd.clr_step) begin
         left_we  = 1'b1;
         right_we = 1'b1;
         wr_addr  = clr_ff;
         left_wd  = LEFT_UNTOUCHED;
         right_wd = '0;
      end else begin
         left_we  = s2_valid_ff && (LEFT_W'(s2_xi_ff) < left_rd_ff);
         right_we = s2_valid_ff && (s2_xi_ff > right_rd_ff);
         wr_addr  = s2_row_ff;
         left_wd  = LEFT_W'(s2_xi_ff);
         right_wd = s2_xi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[wr_addr] <= left_wd;
      end
      if (right_we) begin
         right_mem[wr_addr] <= right_wd;
      end
      if (rd_en) begin
         left_rd_ff  <= left_mem[rd_addr];
         right_rd_ff <= right_mem[rd_addr];
      end
   end

   // vertex registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else begin
         if (cmd.accept && item_first) begin
            prev_x_ff  <= item_x;
            prev_y_ff  <= item_y;
            start_x_ff <= item_x;
            start_y_ff <= item_y;
         end else if (cmd.load_edge && cmd.edge_sel == EDGE_PREV_TO_CUR) begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_x_ff <= item_x;
         cur_y_ff <= item_y;
      end
      if (cmd.q_read) begin
         q_ok_ff <= (RW'(cur_y_ff) < RW'(SCREEN_ROWS));
      end
      if (cmd.load_edge) begin
         num_ff <= {dx_mag, {SLOPE_FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         dy_ff  <= hi_y - lo_y;
         neg_ff <= dx[COORD_W];
         x_ff   <= {lo_x, {SLOPE_FRAC_BITS{1'b0}}};
         row_ff <= lo_y;
         top_ff <= hi_y;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? COORD_W'(rem_sh - {1'b0, dy_ff}) : rem_sh[COORD_W-1:0];
         num_ff <= {num_ff[XW-2:0], q_bit};
      end else if (cmd.walk_step) begin
         x_ff   <= neg_ff ? (x_ff - num_ff) : (x_ff + num_ff);
         row_ff <= row_ff + 1'b1;
      end
      if (cmd.walk_step) begin
         s2_row_ff <= AW'(row_ff);
         s2_xi_ff  <= x_ff[XW-1:SLOPE_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         cnt_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= sts.clr_last ? '0 : clr_ff + 1'b1;
         end
         if (cmd.load_edge) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         s2_valid_ff <= cmd.walk_step && row_ok;
      end
   end

   assign sts.clr_last  = (clr_ff == AW'(SCREEN_ROWS - 1));
   assign sts.div_last  = (cnt_ff == CW'(XW - 1));
   assign sts.walk_last = (row_ff == top_ff);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   // output register
   assign q_left  = q_ok_ff ? left_rd_ff  : LEFT_UNTOUCHED;
   assign q_right = q_ok_ff ? right_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         span_valid_ff <= (q_left <= LEFT_W'(q_right));
         span_left_ff  <= q_left;
         span_right_ff <= q_right;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign span_valid = span_valid_ff;
   assign span_left  = span_left_ff;
   assign span_right = span_right_ff;

`ifndef ASSERT_OFF
   a_no_walk_during_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !s2_valid_ff)
      else $error("walk write collides with clearing pass");
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten");
   a_walk_after_division: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step && !$past(cmd.walk_step)) |-> $past(cmd.div_step))
      else $error("walk started before slope was ready");
`endif

endmodule

// ----- hw/rtl/scanline_polygon_fill_core.sv -----
// Scanline polygon fill core.
// Input channel (req_): one item per transfer, either a polygon vertex or a row query.
// A first vertex clears the edge tables; each later vertex walks the edge from the
// previous vertex, and a last vertex also walks the closing edge to the first one.
// Result channel (rsp_): one transfer per row query with the row's span; vertex
// items give no result. Pixels span_left .. span_right are filled when span_valid.
// A query is read from the row tables, then its answer moves to the output
// register once that register is free; the input is ready again once it is loaded.
// A walked edge loads its endpoints, then computes its slope one quotient bit
// per cycle in the slope divider, then walks one table row per cycle,
// a pipelined read-modify-write with one read and one write port on the row tables.
// A first vertex adds a clearing pass over all SCREEN_ROWS table rows.
// Reset starts the same clearing pass; req_tready stays low until it ends.
// Start and previous vertex return to (0,0).
// The answer waits in an output register while rsp_tready is low; vertex items
// are still accepted meanwhile, a further query waits until the register frees.
// depends on spf_pkg, spf_ctrl, spf_dpath

module scanline_polygon_fill_core import spf_pkg::*; #(
   parameter int SCREEN_ROWS     = DEF_SCREEN_ROWS,
   parameter int SLOPE_FRAC_BITS = DEF_SLOPE_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pos_x [8:0], pos_y [17:9], zero pad
   input  logic [1:0]  req_tuser,   // kind [0], first_vertex [1]
   input  logic        req_tlast,   // last_vertex
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // span_valid [0], span_left [10:1], span_right [19:11]
);

   spf_cmd_type        cmd;
   spf_sts_type        sts;
   logic               span_valid;
   logic [LEFT_W-1:0]  span_left;
   logic [COORD_W-1:0] span_right;

   spf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .item_kind  (req_tuser[0]),
      .item_first (req_tuser[1]),
      .item_last  (req_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   spf_dpath #(
      .SCREEN_ROWS     (SCREEN_ROWS),
      .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .item_x     (req_tdata[8:0]),
      .item_y     (req_tdata[17:9]),
      // a row query never starts a polygon
      .item_first (req_tuser[1] && (req_tuser[0] == KIND_VERTEX)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .span_valid (span_valid),
      .span_left  (span_left),
      .span_right (span_right)
   );

   assign rsp_tdata = {4'b0, span_right, span_left, span_valid};

endmodule

// ----- test/tb_scanline_polygon_fill_core.sv -----
// testbench for scanline_polygon_fill_core: vertex and row-query stimulus, span prediction
// from a behavioral edge-table model, in-order checking of every result transfer
// depends on spf_pkg and the core

`timescale 1ns / 1ps

module tb_scanline_polygon_fill_core;
   import spf_pkg::*;

   localparam int ROWS        = DEF_SCREEN_ROWS;
   localparam int FRAC        = DEF_SLOPE_FRAC_BITS;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int DRAIN_WAIT  = 700;
   localparam int HOLD_CYCLES = 3000;

   // packed to match rsp_tdata: valid lowest, then left, then right
   typedef struct packed {
      logic [COORD_W-1:0] right;
      logic [LEFT_W-1:0]  left;
      logic               valid;
   } span_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   scanline_polygon_fill_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state
   logic [LEFT_W-1:0]  left_row  [ROWS];
   logic [COORD_W-1:0] right_row [ROWS];
   logic [COORD_W-1:0] start_x, start_y, prev_x, prev_y;

   span_type span_queue [$];
   int error_count = 0;
   int sent_count  = 0;
   int cycle_count = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return COORD_W'($urandom_range(0, 511));
   endfunction

   task automatic clear_rows();
      for (int r = 0; r < ROWS; r++) begin
         left_row[r]  = LEFT_UNTOUCHED;
         right_row[r] = '0;
      end
   endtask

   task automatic trace_edge(input longint ax, input longint ay, input longint bx,
                             input longint by);
      longint t, dx, dy, slope, x, xs, mag;
      if (by < ay) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      dx = bx - ax;
      dy = by - ay;
      mag = (dx < 0 ? -dx : dx) <<< FRAC;
      if (dy != 0) mag = mag / dy;
      slope = dx < 0 ? -mag : mag;
      x = ax <<< FRAC;
      for (longint row = ay; row <= by; row++) begin
         if (row < ROWS) begin
            xs = x < 0 ? 0 : x;
            if (xs < (longint'(left_row[row]) <<< FRAC))
               left_row[row] = LEFT_W'(xs >>> FRAC);
            if (xs > (longint'(right_row[row]) <<< FRAC))
               right_row[row] = COORD_W'(xs >>> FRAC);
         end
         x += slope;
      end
   endtask

   task automatic predict_item(input logic kind, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic first,
                               input logic last);
      span_type s;
      if (kind == KIND_QUERY) begin
         s.left  = left_row[y];
         s.right = right_row[y];
         s.valid = (s.left <= LEFT_W'(s.right));
         span_queue.push_back(s);
      end else begin
         if (first) begin
            clear_rows();
            start_x = x;
            start_y = y;
         end else begin
            trace_edge(prev_x, prev_y, x, y);
         end
         if (last) trace_edge(x, y, start_x, start_y);
         prev_x = x;
         prev_y = y;
      end
   endtask

   task automatic send_item(input logic kind, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic first,
                            input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, y, x};
      req_tuser  <= {first, kind};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_item(kind, x, y, first, last);
      sent_count++;
   endtask

   task automatic send_vertex(input int x, input int y, input logic first, input logic last);
      send_item(KIND_VERTEX, COORD_W'(x), COORD_W'(y), first, last);
   endtask

   task automatic send_query(input int y);
      send_item(KIND_QUERY, COORD_W'($urandom_range(0, 511)), COORD_W'(y),
                1'($urandom), 1'($urandom));
   endtask

   // result side: in-order compare
   always @(posedge clock) begin
      span_type got, want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = span_type'(rsp_tdata[19:0]);
            if (span_queue.size() == 0) begin
               $error("unexpected result transfer, data %h", rsp_tdata);
               error_count++;
            end else begin
               want = span_queue.pop_front();
               if (got.valid !== want.valid) begin
                  $error("span_valid expected %0d actual %0d", want.valid, got.valid);
                  error_count++;
               end
               if (got.left !== want.left) begin
                  $error("span_left expected %0d actual %0d", want.left, got.left);
                  error_count++;
               end
               if (got.right !== want.right) begin
                  $error("span_right expected %0d actual %0d", want.right, got.right);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver back-pressure: random, with a long hold when a test asks for one
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 199) == 0) begin
            hold_left <= $urandom_range(20, 80);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 70);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_scanline_polygon_fill_core: errors");
         $finish;
      end
   end

   task automatic test_reset_state();
      // previous vertex starts at the origin before any first vertex
      send_query(0);
      send_query(511);
      send_vertex(40, 10, 1'b0, 1'b0);
      send_query(5);
   endtask

   task automatic test_directed_polygons();
      // full-screen quad touching every extreme
      send_vertex(0, 0, 1'b1, 1'b0);
      send_vertex(511, 0, 1'b0, 1'b0);
      send_vertex(511, 511, 1'b0, 1'b0);
      send_vertex(0, 511, 1'b0, 1'b1);
      send_query(0);
      send_query(255);
      send_query(511);
      // triangle with a horizontal edge and a falling edge
      send_vertex(300, 100, 1'b1, 1'b0);
      send_vertex(100, 100, 1'b0, 1'b0);
      send_vertex(200, 400, 1'b0, 1'b1);
      send_query(100);
      send_query(250);
      send_query(400);
      send_query(401);
   endtask

   task automatic test_special_cases();
      // first and last together: closing edge is the point itself
      send_vertex(77, 33, 1'b1, 1'b1);
      send_query(33);
      send_query(34);
      // steep and shallow edges
      send_vertex(0, 0, 1'b1, 1'b0);
      send_vertex(1, 511, 1'b0, 1'b0);
      send_vertex(511, 1, 1'b0, 1'b1);
      send_query(1);
      send_query(510);
   endtask

   task automatic test_random_polygons(input int item_target);
      int n, ylo, yhi, vy;
      while (sent_count < item_target) begin
         if ($urandom_range(0, 99) < 15) begin
            send_item(1'($urandom), pick_coord(), pick_coord(), 1'($urandom), 1'($urandom));
         end else begin
            n = $urandom_range(1, 6);
            ylo = 511;
            yhi = 0;
            for (int i = 0; i < n; i++) begin
               vy = pick_coord();
               if (vy < ylo) ylo = vy;
               if (vy > yhi) yhi = vy;
               send_vertex(pick_coord(), vy, i == 0, i == n - 1);
            end
            repeat ($urandom_range(3, 10)) begin
               if ($urandom_range(0, 9) < 8) send_query($urandom_range(ylo, yhi));
               else send_query(pick_coord());
            end
         end
      end
   endtask

   task automatic test_output_stall();
      send_vertex(10, 20, 1'b1, 1'b0);
      send_vertex(400, 300, 1'b0, 1'b1);
      hold_requests++;
      // the output register fills and further queries stall the input
      repeat (8) send_query($urandom_range(20, 300));
      send_vertex(50, 60, 1'b0, 1'b0);
      repeat (4) send_query($urandom_range(0, 511));
   endtask

   initial begin
      clear_rows();
      start_x = '0; start_y = '0; prev_x = '0; prev_y = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_polygons();
      test_special_cases();
      test_output_stall();
      test_random_polygons(1110);
      req_tvalid <= 1'b0;
      while (span_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && span_queue.size() == 0)
         $display("tb_scanline_polygon_fill_core: clean");
      else
         $display("tb_scanline_polygon_fill_core: errors");
      $finish;
   end

endmodule

// ----- scanline_polygon_fill_core.f -----
hw/rtl/spf_pkg.sv
hw/rtl/spf_ctrl.sv
hw/rtl/spf_dpath.sv
hw/rtl/scanline_polygon_fill_core.sv
test/tb_scanline_polygon_fill_core.sv
